// ===== hw/rtl/asl_tag_control_subtraction_unit_defines.svh =====
// Shared assertion macros. Each expects clk and rst_n in scope.
`ifndef ASL_TAG_CONTROL_SUBTRACTION_UNIT_DEFINES_SVH
`define ASL_TAG_CONTROL_SUBTRACTION_UNIT_DEFINES_SVH

// Same-cycle implication
`define ASL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/asl_pkg.sv =====
package asl_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int MAX_PAIRS   = 64;
  localparam int VALUE_W     = 28;
  localparam int CNT_W       = 7;
  localparam int THR_W       = 19;
  localparam int SCHEME_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 19;
  // wide enough for a halved sum minus a sample, and for a sum plus a difference
  localparam int WIDE_W = (SAMPLE_BITS + 2 > VALUE_W + 1) ? SAMPLE_BITS + 2 : VALUE_W + 1;
  localparam int DIV_STEPS   = VALUE_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // subtraction schemes
  localparam logic [SCHEME_W-1:0] SCHEME_STRICT   = 2'd0;
  localparam logic [SCHEME_W-1:0] SCHEME_ADJACENT = 2'd1;
  localparam logic [SCHEME_W-1:0] SCHEME_SURROUND = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCHEME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIRS     = 2'd2;

  localparam logic signed [WIDE_W-1:0] VMAX_W = WIDE_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] VMIN_W = -VMAX_W - WIDE_W'(1);

  // one work item handed from front to back
  typedef struct packed {
    logic [1:0]                 ndiff;
    logic signed [VALUE_W-1:0]  d0;
    logic signed [VALUE_W-1:0]  d1;
    logic [CNT_W-1:0]           num0;
    logic                       mean;
    logic                       mean_ok;
    logic signed [VALUE_W-1:0]  sum;
    logic [CNT_W-1:0]           cnt;
  } job_t;

  // clamp to the signed result range
  function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [WIDE_W-1:0] v);
    logic signed [VALUE_W-1:0] r;
    if (v > VMAX_W) r = VALUE_W'(VMAX_W);
    else if (v < VMIN_W) r = VALUE_W'(VMIN_W);
    else r = VALUE_W'(v);
    return r;
  endfunction

endpackage

// ===== hw/rtl/asl_in_if.sv =====
interface asl_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [asl_pkg::SAMPLE_BITS-1:0] tag_on;
  logic signed [asl_pkg::SAMPLE_BITS-1:0] tag_off;

  modport source (output valid, tag_on, tag_off, input ready);
  modport sink   (input valid, tag_on, tag_off, output ready);
endinterface

// ===== hw/rtl/asl_out_if.sv =====
interface asl_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [asl_pkg::VALUE_W-1:0] value;
  logic                               is_mean;
  logic [asl_pkg::CNT_W-1:0]          diff_number;
  logic                               zero_count;
  logic                               last;

  modport source (output valid, value, is_mean, diff_number, zero_count, last, input ready);
  modport sink   (input valid, value, is_mean, diff_number, zero_count, last, output ready);
endinterface

// ===== hw/rtl/asl_front.sv =====
module asl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [asl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asl_pkg::CFG_DATA_W-1:0] cfg_data,
  asl_in_if.sink                         in_ch,
  input  logic                           q_full,
  output logic                           q_push,
  output asl_pkg::job_t                  q_job
);

  localparam int W  = asl_pkg::WIDE_W;
  localparam int VW = asl_pkg::VALUE_W;
  localparam int CW = asl_pkg::CNT_W;

  logic [asl_pkg::SCHEME_W-1:0]          scheme_r;
  logic [asl_pkg::THR_W-1:0]             thr_r;
  logic [CW-1:0]                         pairs_r;
  logic [CW-1:0]                         pair_idx_r, pair_idx_nxt;
  logic signed [asl_pkg::SAMPLE_BITS-1:0] prev_on_r, prev_off_r;
  logic                                  active_r, active_nxt;
  logic signed [VW-1:0]                  sum_r, sum_nxt;
  logic [CW-1:0]                         cnt_r, cnt_nxt;

  logic                  fire, first, active, last_pair;
  logic [CW-1:0]         pc_eff, cnt_base;
  logic [1:0]            n;
  logic signed [W-1:0]   on_w, off_w, pon_w, poff_w, thr_w;
  logic signed [VW-1:0]  d0, d1, sum_base, sum1, sum2;

  assign fire        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r <= asl_pkg::SCHEME_STRICT;
      thr_r    <= '0;
      pairs_r  <= CW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        asl_pkg::CFG_SCHEME:    scheme_r <= cfg_data[asl_pkg::SCHEME_W-1:0];
        asl_pkg::CFG_THRESHOLD: thr_r    <= cfg_data[asl_pkg::THR_W-1:0];
        asl_pkg::CFG_PAIRS:     pairs_r  <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // operand extension
  assign on_w   = W'(in_ch.tag_on);
  assign off_w  = W'(in_ch.tag_off);
  assign pon_w  = W'(prev_on_r);
  assign poff_w = W'(prev_off_r);
  assign thr_w  = $signed(W'(thr_r));

  // pixel bookkeeping
  assign first  = (pair_idx_r == '0);
  assign active = first ? (on_w > thr_w) : active_r;
  assign pc_eff = (pairs_r == '0) ? CW'(1) :
                  (pairs_r > CW'(asl_pkg::MAX_PAIRS)) ? CW'(asl_pkg::MAX_PAIRS) : pairs_r;
  assign last_pair = ({1'b0, pair_idx_r} + 8'd1) >= {1'b0, pc_eff};
  assign sum_base  = first ? '0 : sum_r;
  assign cnt_base  = first ? '0 : cnt_r;

  // classify the pair and form its differences
  always_comb begin
    d0 = asl_pkg::sat_value(on_w - off_w);
    d1 = d0;
    n  = 2'd1;
    case (scheme_r)
      asl_pkg::SCHEME_ADJACENT: begin
        if (!first) begin
          d0 = asl_pkg::sat_value(on_w - poff_w);
          d1 = asl_pkg::sat_value(on_w - off_w);
          n  = 2'd2;
        end
      end
      asl_pkg::SCHEME_SURROUND: begin
        d0 = asl_pkg::sat_value(((pon_w + on_w) >>> 1) - poff_w);
        d1 = asl_pkg::sat_value(on_w - ((poff_w + off_w) >>> 1));
        n  = first ? 2'd0 : 2'd2;
      end
      default: ;
    endcase
    if (!active) n = 2'd0;
  end

  // running sum, saturated after each difference
  assign sum1 = (n != 2'd0) ? asl_pkg::sat_value(W'(sum_base) + W'(d0)) : sum_base;
  assign sum2 = (n == 2'd2) ? asl_pkg::sat_value(W'(sum1) + W'(d1)) : sum1;

  always_comb begin
    if (last_pair) begin
      pair_idx_nxt = '0;
      active_nxt   = 1'b0;
      sum_nxt      = '0;
      cnt_nxt      = '0;
    end else begin
      pair_idx_nxt = CW'(pair_idx_r + 1'b1);
      active_nxt   = active;
      sum_nxt      = sum2;
      cnt_nxt      = CW'(cnt_base + CW'(n));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_idx_r <= '0;
      active_r   <= 1'b0;
      sum_r      <= '0;
      cnt_r      <= '0;
      prev_on_r  <= '0;
      prev_off_r <= '0;
    end else if (fire) begin
      pair_idx_r <= pair_idx_nxt;
      active_r   <= active_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      prev_on_r  <= in_ch.tag_on;
      prev_off_r <= in_ch.tag_off;
    end
  end

  // job for the back end; pairs with nothing to show are dropped
  assign q_push       = fire && ((n != 2'd0) || last_pair);
  assign q_job.ndiff  = n;
  assign q_job.d0     = d0;
  assign q_job.d1     = d1;
  assign q_job.num0   = cnt_base;
  assign q_job.mean   = last_pair;
  assign q_job.cnt    = CW'(cnt_base + CW'(n));
  assign q_job.mean_ok = active && (q_job.cnt != '0);
  assign q_job.sum    = sum2;

endmodule

// ===== hw/rtl/asl_job_queue.sv =====
module asl_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  asl_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output asl_pkg::job_t pop_job,
  output logic          empty
);

  asl_pkg::job_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    fill_r;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/asl_back.sv =====
`include "asl_tag_control_subtraction_unit_defines.svh"

module asl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  asl_pkg::job_t q_job,
  output logic          q_pop,
  asl_out_if.source     out_ch
);

  localparam int VW = asl_pkg::VALUE_W;
  localparam int CW = asl_pkg::CNT_W;
  localparam int DW = asl_pkg::DIV_CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_D0   = 3'd1;
  localparam logic [2:0] ST_D1   = 3'd2;
  localparam logic [2:0] ST_TAIL = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_MEAN = 3'd5;

  localparam logic [DW-1:0] DIV_LAST = DW'(asl_pkg::DIV_STEPS - 1);

  logic [2:0]           st_r, st_nxt;
  asl_pkg::job_t        job_r, job_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [VW-1:0]        dvd_r, dvd_nxt;
  logic [DW-1:0]        dcnt_r, dcnt_nxt;

  logic                 ov_r, ov_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logic                 ism_r, ism_nxt;
  logic [CW-1:0]        num_r, num_nxt;
  logic                 zc_r, zc_nxt;
  logic                 last_r, last_nxt;

  logic                 out_free;
  logic [CW:0]          trial;
  logic                 take;
  logic [VW-1:0]        mag, quo;

  assign out_free = !ov_r || out_ch.ready;

  // restoring divider step: one quotient bit per cycle
  assign trial = {rem_r, dvd_r[VW-1]};
  assign take  = trial >= {1'b0, job_r.cnt};
  assign mag   = job_r.sum[VW-1] ? VW'(-job_r.sum) : VW'(job_r.sum);
  assign quo   = job_r.sum[VW-1] ? VW'(-dvd_r) : dvd_r;

  always_comb begin
    st_nxt   = st_r;
    job_nxt  = job_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dcnt_nxt = dcnt_r;
    q_pop    = 1'b0;
    ov_nxt   = ov_r && !out_ch.ready;
    val_nxt  = val_r;
    ism_nxt  = ism_r;
    num_nxt  = num_r;
    zc_nxt   = zc_r;
    last_nxt = last_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          st_nxt  = (q_job.ndiff != 2'd0) ? ST_D0 : ST_TAIL;
        end
      end
      ST_D0: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          val_nxt  = job_r.d0;
          ism_nxt  = 1'b0;
          num_nxt  = job_r.num0;
          zc_nxt   = 1'b0;
          last_nxt = 1'b0;
          st_nxt   = (job_r.ndiff == 2'd2) ? ST_D1 : ST_TAIL;
        end
      end
      ST_D1: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          val_nxt  = job_r.d1;
          ism_nxt  = 1'b0;
          num_nxt  = CW'(job_r.num0 + 1'b1);
          zc_nxt   = 1'b0;
          last_nxt = 1'b0;
          st_nxt   = ST_TAIL;
        end
      end
      ST_TAIL: begin
        rem_nxt  = '0;
        dvd_nxt  = mag;
        dcnt_nxt = '0;
        if (!job_r.mean) st_nxt = ST_IDLE;
        else if (job_r.mean_ok) st_nxt = ST_DIV;
        else st_nxt = ST_MEAN;
      end
      ST_DIV: begin
        rem_nxt  = take ? CW'(trial - {1'b0, job_r.cnt}) : trial[CW-1:0];
        dvd_nxt  = {dvd_r[VW-2:0], take};
        dcnt_nxt = DW'(dcnt_r + 1'b1);
        if (dcnt_r == DIV_LAST) st_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          val_nxt  = job_r.mean_ok ? $signed(quo) : '0;
          ism_nxt  = 1'b1;
          num_nxt  = '0;
          zc_nxt   = !job_r.mean_ok;
          last_nxt = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // payload and divider datapath
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dcnt_r <= dcnt_nxt;
    val_r  <= val_nxt;
    ism_r  <= ism_nxt;
    num_r  <= num_nxt;
    zc_r   <= zc_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.value       = val_r;
  assign out_ch.is_mean     = ism_r;
  assign out_ch.diff_number = num_r;
  assign out_ch.zero_count  = zc_r;
  assign out_ch.last        = last_r;

  `ASL_ASSERT_IMPLY(a_mean_is_last, ov_r, ism_r == last_r, "mean and last disagree")
  `ASL_ASSERT_IMPLY(a_zc_value, ov_r && zc_r, val_r == '0 && ism_r, "zero count with value")
  `ASL_ASSERT_IMPLY(a_div_nonzero, st_r == ST_DIV, job_r.cnt != '0, "divide by zero count")
  `ASL_ASSERT_IMPLY(a_div_bound, st_r == ST_DIV, dcnt_r <= DIV_LAST, "divider overran")
  `ASL_ASSERT_NEXT(a_div_done, st_r == ST_DIV && dcnt_r == DIV_LAST, st_r == ST_MEAN,
                   "divider did not finish")

endmodule

// ===== hw/rtl/asl_tag_control_subtraction_unit.sv =====
// Channel  Dir  Payload                                               Handshake
// in_ch    in   tag_on, tag_off (signed Q16.4)                        valid/ready
// out_ch   out  value, is_mean, diff_number, zero_count, last         valid/ready
// cfg_*    in   cfg_index selects scheme, noise_threshold, pair_count write only
//
// Front takes one pair beat per cycle while the 2-entry job queue has room.
// Back: pops a job, sends one beat per difference, then closes the job;
// a mean adds a division (skipped on zero count) and a beat to send it.
// Reset is synchronous and clears control and pixel state; no clearing pass.
// Either side may stall on its own; the output register holds a stalled beat.
module asl_tag_control_subtraction_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [asl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asl_pkg::CFG_DATA_W-1:0] cfg_data,
  asl_in_if.sink                         in_ch,
  asl_out_if.source                      out_ch
);

  logic          q_full, q_empty, q_push, q_pop;
  asl_pkg::job_t push_job, pop_job;

  asl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  asl_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  asl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== dv/asl_tag_control_subtraction_unit_test.sv =====
`timescale 1ns / 100ps

module asl_tag_control_subtraction_unit_test;

  localparam int SB = asl_pkg::SAMPLE_BITS;
  localparam int VW = asl_pkg::VALUE_W;
  localparam int CW = asl_pkg::CNT_W;
  localparam int TW = asl_pkg::THR_W;
  localparam int SW = asl_pkg::SCHEME_W;
  localparam int IW = asl_pkg::CFG_IDX_W;
  localparam int DW = asl_pkg::CFG_DATA_W;

  localparam int CYCLE_LIMIT  = 200000;
  // allow margin for the divider and control before touching registers
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 16;
  localparam logic [SW-1:0] SCHEME_UNUSED = 2'd3;
  localparam logic signed [SB-1:0] SAMPLE_HI = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_LO = {1'b1, {(SB-1){1'b0}}};
  localparam logic [TW-1:0] THR_MAX = {TW{1'b1}};
  localparam longint VALUE_HI = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam longint VALUE_LO = -VALUE_HI - 64'sd1;

  // one result beat as the block should send it
  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 is_mean;
    logic [CW-1:0]        diff_number;
    logic                 zero_count;
    logic                 last;
  } subtraction_beat_t;

  // directed stimulus; typed rows carry the pixel mean that closes them
  typedef struct packed {
    logic [SW-1:0]        scheme;
    logic [TW-1:0]        thr;
    logic [CW-1:0]        pairs;
    logic signed [SB-1:0] tag_on;
    logic signed [SB-1:0] tag_off;
    logic                 typed;
    logic signed [VW-1:0] mean;
    logic                 mean_zero;
  } stim_row_t;

  localparam int STIM_ROWS = 21;
  stim_row_t stim_rows [STIM_ROWS] = '{
    // single-pair pixels: extremes, threshold edges, unused scheme code, surround
    '{asl_pkg::SCHEME_STRICT, 19'd0, 7'd1, 20'sd524287, -20'sd524288, 1'b1, 28'sd1048575, 1'b0},
    '{asl_pkg::SCHEME_STRICT, 19'd0, 7'd1, -20'sd524288, 20'sd524287, 1'b1, 28'sd0, 1'b1},
    '{asl_pkg::SCHEME_STRICT, 19'd0, 7'd1, 20'sd0, 20'sd0, 1'b1, 28'sd0, 1'b1},
    '{asl_pkg::SCHEME_STRICT, 19'd524287, 7'd1, 20'sd524287, 20'sd0, 1'b1, 28'sd0, 1'b1},
    '{SCHEME_UNUSED, 19'd0, 7'd1, 20'sd100, 20'sd40, 1'b1, 28'sd60, 1'b0},
    '{asl_pkg::SCHEME_SURROUND, 19'd0, 7'd1, 20'sd500, 20'sd3, 1'b1, 28'sd0, 1'b1},
    // adjacent pairs over three pairs
    '{asl_pkg::SCHEME_ADJACENT, 19'd0, 7'd3, 20'sd160, 20'sd32, 1'b0, 28'sd0, 1'b0},
    '{asl_pkg::SCHEME_ADJACENT, 19'd0, 7'd3, -20'sd80, -20'sd16, 1'b0, 28'sd0, 1'b0},
    '{asl_pkg::SCHEME_ADJACENT, 19'd0, 7'd3, 20'sd48, 20'sd24, 1'b0, 28'sd0, 1'b0},
    // surround over two pairs
    '{asl_pkg::SCHEME_SURROUND, 19'd0, 7'd2, 20'sd300, 20'sd100, 1'b0, 28'sd0, 1'b0},
    '{asl_pkg::SCHEME_SURROUND, 19'd0, 7'd2, -20'sd7, 20'sd55, 1'b0, 28'sd0, 1'b0},
    // pair count zero acts as one
    '{asl_pkg::SCHEME_STRICT, 19'd0, 7'd0, 20'sd50, -20'sd50, 1'b1, 28'sd100, 1'b0},
    '{asl_pkg::SCHEME_STRICT, 19'd5, 7'd0, 20'sd5, -20'sd50, 1'b1, 28'sd0, 1'b1},
    // scheme and count changed inside a pixel
    '{asl_pkg::SCHEME_STRICT, 19'd0, 7'd3, 20'sd200, 20'sd10, 1'b0, 28'sd0, 1'b0},
    '{asl_pkg::SCHEME_ADJACENT, 19'd0, 7'd3, 20'sd300, 20'sd20, 1'b0, 28'sd0, 1'b0},
    '{asl_pkg::SCHEME_ADJACENT, 19'd0, 7'd2, -20'sd9, 20'sd7, 1'b0, 28'sd0, 1'b0},
    // inactive pixel over two pairs
    '{asl_pkg::SCHEME_SURROUND, 19'd0, 7'd2, -20'sd1, 20'sd4, 1'b0, 28'sd0, 1'b0},
    '{asl_pkg::SCHEME_SURROUND, 19'd0, 7'd2, 20'sd9, 20'sd9, 1'b1, 28'sd0, 1'b1},
    // mean of an odd negative sum truncates toward zero
    '{asl_pkg::SCHEME_STRICT, 19'd0, 7'd2, 20'sd524287, 20'sd524287, 1'b0, 28'sd0, 1'b0},
    '{asl_pkg::SCHEME_STRICT, 19'd0, 7'd2, -20'sd524288, 20'sd524287, 1'b1, -28'sd524287,
      1'b0},
    '{asl_pkg::SCHEME_ADJACENT, 19'd0, 7'd1, 20'sd1, -20'sd524288, 1'b1, 28'sd524289, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic          cfg_we;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  asl_in_if  in_ch ();
  asl_out_if out_ch ();

  asl_tag_control_subtraction_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // register shadows
  logic [SW-1:0] reg_scheme = asl_pkg::SCHEME_STRICT;
  logic [TW-1:0] reg_thr    = '0;
  logic [CW-1:0] reg_pairs  = 7'd1;

  // pixel state of the predictor
  int            pair_idx   = 0;
  longint        prev_on    = 0;
  longint        prev_off   = 0;
  bit            px_active  = 1'b0;
  longint        run_sum    = 0;
  logic [CW-1:0] run_count  = '0;

  subtraction_beat_t results_due [$];
  subtraction_beat_t head_result;
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 47;
  int mismatch_count = 0;
  int cycle_count = 0;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // compare each result beat against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing due: value %0d last %0b", out_ch.value, out_ch.last);
        mismatch_count++;
      end else begin
        head_result = results_due.pop_front();
        if (out_ch.value !== head_result.value) begin
          $error("value: expected %0d, got %0d", head_result.value, out_ch.value);
          mismatch_count++;
        end
        if (out_ch.is_mean !== head_result.is_mean) begin
          $error("is_mean: expected %0b, got %0b", head_result.is_mean, out_ch.is_mean);
          mismatch_count++;
        end
        if (out_ch.diff_number !== head_result.diff_number) begin
          $error("diff_number: expected %0d, got %0d", head_result.diff_number,
                 out_ch.diff_number);
          mismatch_count++;
        end
        if (out_ch.zero_count !== head_result.zero_count) begin
          $error("zero_count: expected %0b, got %0b", head_result.zero_count,
                 out_ch.zero_count);
          mismatch_count++;
        end
        if (out_ch.last !== head_result.last) begin
          $error("last: expected %0b, got %0b", head_result.last, out_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  function automatic longint clamp_value(longint v);
    if (v > VALUE_HI) return VALUE_HI;
    if (v < VALUE_LO) return VALUE_LO;
    return v;
  endfunction

  // count 0 acts as 1, anything above the maximum as the maximum
  function automatic int pairs_in_pixel();
    if (reg_pairs == 0) return 1;
    if (reg_pairs > asl_pkg::MAX_PAIRS) return asl_pkg::MAX_PAIRS;
    return int'(reg_pairs);
  endfunction

  // queue one difference beat and fold it into the running sum
  function automatic void log_difference(longint d);
    subtraction_beat_t b;
    d = clamp_value(d);
    b.value       = VW'(d);
    b.is_mean     = 1'b0;
    b.diff_number = run_count;
    b.zero_count  = 1'b0;
    b.last        = 1'b0;
    results_due.push_back(b);
    run_sum   = clamp_value(run_sum + d);
    run_count = run_count + 1'b1;
  endfunction

  // expected beats caused by one accepted pair
  function automatic void subtract_pair(logic signed [SB-1:0] on_s,
                                        logic signed [SB-1:0] off_s);
    longint on_v;
    longint off_v;
    subtraction_beat_t b;
    on_v  = on_s;
    off_v = off_s;
    if (pair_idx == 0) begin
      px_active = (on_v > longint'(reg_thr));
      run_sum   = 0;
      run_count = '0;
    end
    if (px_active) begin
      case (reg_scheme)
        asl_pkg::SCHEME_ADJACENT: begin
          if (pair_idx != 0) log_difference(on_v - prev_off);
          log_difference(on_v - off_v);
        end
        asl_pkg::SCHEME_SURROUND: begin
          // halving is a floor shift
          if (pair_idx != 0) begin
            log_difference(((prev_on + on_v) >>> 1) - prev_off);
            log_difference(on_v - ((prev_off + off_v) >>> 1));
          end
        end
        default: log_difference(on_v - off_v);
      endcase
    end
    prev_on  = on_v;
    prev_off = off_v;
    if (pair_idx + 1 >= pairs_in_pixel()) begin
      b.is_mean     = 1'b1;
      b.diff_number = '0;
      b.last        = 1'b1;
      if (px_active && run_count != 0) begin
        b.value      = VW'(run_sum / longint'(run_count));
        b.zero_count = 1'b0;
      end else begin
        b.value      = '0;
        b.zero_count = 1'b1;
      end
      results_due.push_back(b);
      pair_idx  = 0;
      px_active = 1'b0;
      run_sum   = 0;
      run_count = '0;
    end else begin
      pair_idx++;
    end
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_HI;
      1: return SAMPLE_LO;
      2: return '0;
      3: return SB'(int'($urandom_range(0, 128)) - 64);
      default: return SB'($urandom);
    endcase
  endfunction

  // a first tag-on sample that clears the threshold, unless the threshold is at its maximum
  function automatic logic signed [SB-1:0] pick_bright_sample();
    if (reg_thr == THR_MAX) return pick_sample();
    return SB'(int'(reg_thr) + 1 + int'($urandom_range(0, int'(THR_MAX) - 1 -
                                                       int'(reg_thr))));
  endfunction

  task automatic send_pair(logic signed [SB-1:0] on_s,
                           logic signed [SB-1:0] off_s);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.tag_on  <= on_s;
    in_ch.tag_off <= off_s;
    do @(posedge clk); while (!in_ch.ready);
    subtract_pair(on_s, off_s);
  endtask

  // drop valid, wait out every due beat and any work that yields none
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [SW-1:0] s, logic [TW-1:0] t,
                            logic [CW-1:0] p);
    cfg_we    <= 1'b1;
    cfg_index <= asl_pkg::CFG_SCHEME;
    cfg_data  <= DW'(s);
    @(posedge clk);
    cfg_index <= asl_pkg::CFG_THRESHOLD;
    cfg_data  <= DW'(t);
    @(posedge clk);
    cfg_index <= asl_pkg::CFG_PAIRS;
    cfg_data  <= DW'(p);
    @(posedge clk);
    cfg_we     <= 1'b0;
    reg_scheme  = s;
    reg_thr     = t;
    reg_pairs   = p;
  endtask

  // one whole pixel of random pairs, mostly with a bright first sample
  task automatic send_pixel(output int sent);
    int n;
    logic signed [SB-1:0] on_s;
    n = pairs_in_pixel();
    for (int k = 0; k < n; k++) begin
      if (k == 0 && $urandom_range(0, 9) != 0) on_s = pick_bright_sample();
      else on_s = pick_sample();
      send_pair(on_s, pick_sample());
    end
    sent = n;
  endtask

  initial begin
    stim_row_t row;
    subtraction_beat_t closing;
    logic [TW-1:0] thr_pick;
    logic [CW-1:0] pairs_pick;
    int sent;
    int phase_items;
    bit held_off;

    clk            = 1'b0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= asl_pkg::CFG_SCHEME;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.tag_on  <= '0;
    in_ch.tag_off <= '0;
    held_off       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int r = 0; r < STIM_ROWS; r++) begin
      row = stim_rows[r];
      if (row.scheme != reg_scheme || row.thr != reg_thr || row.pairs != reg_pairs) begin
        settle_block();
        write_regs(row.scheme, row.thr, row.pairs);
      end
      send_pair(row.tag_on, row.tag_off);
      if (row.typed) begin
        closing            = results_due.pop_back();
        closing.value      = row.mean;
        closing.zero_count = row.mean_zero;
        results_due.push_back(closing);
      end
    end

    // random phases, each with its own register setting
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == RAND_PHASES / 3) begin
        tx_idle_pct = 47;
        rx_idle_pct = 10;
      end else if (phase == 2 * RAND_PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(0, 5))
        0: thr_pick = '0;
        1: thr_pick = THR_MAX;
        2: thr_pick = TW'($urandom);
        default: thr_pick = TW'($urandom_range(0, 255));
      endcase
      if (phase == 3) begin
        pairs_pick = CW'(asl_pkg::MAX_PAIRS);
      end else if (phase == 9) begin
        pairs_pick = CW'($urandom_range(asl_pkg::MAX_PAIRS + 1, 127));
      end else begin
        case ($urandom_range(0, 9))
          0: pairs_pick = '0;
          1: pairs_pick = 7'd1;
          default: pairs_pick = CW'($urandom_range(2, 8));
        endcase
      end
      settle_block();
      write_regs(SW'($urandom_range(0, 3)), thr_pick, pairs_pick);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_pixel(sent);
        phase_items += sent;
        // hold the sender off until the block has drained
        if (phase == 5 && !held_off) begin
          held_off = 1'b1;
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (results_due.size() != 0);
        end
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/asl_pkg.sv
hw/rtl/asl_in_if.sv
hw/rtl/asl_out_if.sv
hw/rtl/asl_front.sv
hw/rtl/asl_job_queue.sv
hw/rtl/asl_back.sv
hw/rtl/asl_tag_control_subtraction_unit.sv
dv/asl_tag_control_subtraction_unit_test.sv
